>>> rtl/core/hgt_pkg.sv
package hgt_pkg;

   // tile geometry
   localparam int MAX_COLUMNS = 4096;
   localparam int ROW_LIMIT   = 4096;
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS    = $clog2(ROW_LIMIT);
   localparam int INDEX_BITS  = 24;
   localparam int SIZE_BITS   = 13;
   localparam int ELEV_BITS   = 32;

   // register file
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_COLUMNS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_ROWS     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODATA_ENABLE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODATA_VALUE  = 2'd3;

   typedef logic [INDEX_BITS-1:0] idx_type;
   typedef logic [ELEV_BITS-1:0]  elev_type;

   // both triangles of one grid cell, handed to the output stage
   typedef struct packed {
      idx_type left;
      idx_type up;
      idx_type up_left;
      idx_type here;
      logic    frozen;
      logic    keep_lo;
      logic    keep_hi;
   } tri_pair_type;

   // single-precision equality: nan never matches, +0 matches -0
   function automatic logic float_match(input elev_type a, input elev_type b);
      logic nan_a;
      logic nan_b;
      logic both_zero;
      nan_a     = a[ELEV_BITS-2:0] > 31'h7F80_0000;
      nan_b     = b[ELEV_BITS-2:0] > 31'h7F80_0000;
      both_zero = (a[ELEV_BITS-2:0] | b[ELEV_BITS-2:0]) == '0;
      return !nan_a && !nan_b && (both_zero || (a == b));
   endfunction

endpackage

>>> rtl/core/hgt_tri_out.sv
module hgt_tri_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   output logic                 load_ready,
   input  hgt_pkg::tri_pair_type pair,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hgt_pkg::idx_type     rsp_corner_a,
   output hgt_pkg::idx_type     rsp_corner_b,
   output hgt_pkg::idx_type     rsp_corner_c,
   output logic                 rsp_frozen,
   output logic                 rsp_second_half,
   output logic                 rsp_last
);
   import hgt_pkg::*;

   tri_pair_type pair_ff;
   logic         lo_ff;
   logic         hi_ff;
   logic         lo_in;
   logic         hi_in;
   logic         beat;

   assign rsp_valid  = lo_ff | hi_ff;
   assign beat       = rsp_valid & rsp_ready;
   // free now, or the beat going out is the last one of the pair
   assign load_ready = !rsp_valid || (rsp_ready && !(lo_ff && hi_ff));

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (load_valid && load_ready) begin
         lo_in = pair.keep_lo;
         hi_in = pair.keep_hi;
      end else if (beat) begin
         if (lo_ff) begin
            lo_in = 1'b0;
         end else begin
            hi_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= 1'b0;
         hi_ff <= 1'b0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         pair_ff <= pair;
      end
   end

   // lower-left goes first when kept
   assign rsp_corner_a    = pair_ff.left;
   assign rsp_corner_b    = lo_ff ? pair_ff.up      : pair_ff.here;
   assign rsp_corner_c    = lo_ff ? pair_ff.up_left : pair_ff.up;
   assign rsp_frozen      = pair_ff.frozen;
   assign rsp_second_half = !lo_ff;
   assign rsp_last        = !(lo_ff && hi_ff);

endmodule

>>> rtl/core/height_grid_triangulator.sv
// Height grid triangulator. Elevation samples of one tile stream in row-major
// order, one per req_ beat; the block tracks column, row and running vertex
// index itself. Every sample with column and row both above zero closes a
// grid cell and yields up to two triangles on rsp_: the lower-left one
// (index-1, index-C, index-C-1) and then the upper-right one (index-1, index,
// index-C), with C the clamped column count. frozen marks cells on the border
// ring, last marks the final triangle of a sample. With nodata enabled, a
// triangle touching a sample equal to nodata_value (as a float: nan never
// matches, +0 equals -0) is dropped. Nodata flags of the row above live in a
// 4096 x 1 single-port read-first line store, read and written at the
// sample's column in the accept cycle; its contents are undefined after reset
// and need no clearing, since a flag is always written one row before it is
// read. Rate: one sample per cycle while rsp_ready holds; a sample with two
// triangles holds the next back until its second leaves the one result port.
// Samples pass the stage one and output stage registers. Configuration must be
// written through csr_ only while the block is idle; it does not enforce this.
module height_grid_triangulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [hgt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hgt_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hgt_pkg::elev_type                 req_elevation,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hgt_pkg::idx_type                  rsp_corner_a,
   output hgt_pkg::idx_type                  rsp_corner_b,
   output hgt_pkg::idx_type                  rsp_corner_c,
   output logic                              rsp_frozen,
   output logic                              rsp_second_half,
   output logic                              rsp_last
);
   import hgt_pkg::*;

   // configuration registers
   logic [SIZE_BITS-1:0] grid_columns_ff;
   logic [SIZE_BITS-1:0] grid_rows_ff;
   logic                 nodata_enable_ff;
   elev_type             nodata_value_ff;

   // effective tile size after saturation
   logic [SIZE_BITS-1:0] cols_eff;
   logic [SIZE_BITS-1:0] rows_eff;

   // position tracking
   logic [COL_BITS-1:0]  col_ff;
   logic [ROW_BITS-1:0]  row_ff;
   idx_type              idx_ff;
   logic [SIZE_BITS-1:0] col_next;
   logic [SIZE_BITS-1:0] row_next;
   logic                 col_wrap;
   logic                 row_wrap;

   // nodata flags
   logic                 here_nodata;
   logic                 left_ff;
   logic                 line_mem [MAX_COLUMNS];
   logic                 line_rd_ff;

   // stage one: sample accepted, waiting on the line store read
   logic                 s1_valid_ff;
   logic                 s1_cell_ff;
   logic                 s1_frozen_ff;
   idx_type              s1_idx_ff;
   logic                 s1_left_ff;
   logic                 s1_up_left_ff;
   logic                 s1_here_ff;
   logic                 s1_valid_in;
   logic                 s1_move;

   logic                 req_fire;
   logic                 frozen_now;
   logic                 cell_now;

   tri_pair_type         pair;
   logic                 pair_any;
   logic                 out_ready;

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff  <= SIZE_BITS'(2);
         grid_rows_ff     <= SIZE_BITS'(2);
         nodata_enable_ff <= 1'b0;
         nodata_value_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS:  grid_columns_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_GRID_ROWS:     grid_rows_ff     <= csr_data[SIZE_BITS-1:0];
            CSR_NODATA_ENABLE: nodata_enable_ff <= csr_data[0];
            CSR_NODATA_VALUE:  nodata_value_ff  <= csr_data[ELEV_BITS-1:0];
            default: ;
         endcase
      end
   end

   // saturate tile size to the supported range
   always_comb begin
      priority if (grid_columns_ff < SIZE_BITS'(2)) begin
         cols_eff = SIZE_BITS'(2);
      end else if (grid_columns_ff > SIZE_BITS'(MAX_COLUMNS)) begin
         cols_eff = SIZE_BITS'(MAX_COLUMNS);
      end else begin
         cols_eff = grid_columns_ff;
      end
      priority if (grid_rows_ff < SIZE_BITS'(2)) begin
         rows_eff = SIZE_BITS'(2);
      end else if (grid_rows_ff > SIZE_BITS'(ROW_LIMIT)) begin
         rows_eff = SIZE_BITS'(ROW_LIMIT);
      end else begin
         rows_eff = grid_rows_ff;
      end
   end

   // ------------------------------------------------------------------
   // accept side
   // ------------------------------------------------------------------
   // stage one frees when its pair leaves; the line store output must
   // hold until then, so a new read waits for it
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   assign here_nodata = float_match(req_elevation, nodata_value_ff);

   assign col_next = SIZE_BITS'(col_ff) + SIZE_BITS'(1);
   assign row_next = SIZE_BITS'(row_ff) + SIZE_BITS'(1);
   assign col_wrap = col_next >= cols_eff;
   assign row_wrap = row_next >= rows_eff;

   assign cell_now   = (col_ff != '0) && (row_ff != '0);
   assign frozen_now = (col_ff == COL_BITS'(1)) || (row_ff == ROW_BITS'(1)) ||
                       (SIZE_BITS'(col_ff) == cols_eff - SIZE_BITS'(1)) ||
                       (SIZE_BITS'(row_ff) == rows_eff - SIZE_BITS'(1));

   // position and running index
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         idx_ff  <= '0;
         left_ff <= 1'b0;
      end else if (req_fire) begin
         left_ff <= here_nodata;
         if (col_wrap) begin
            col_ff <= '0;
            if (row_wrap) begin
               // tile done, start over
               row_ff <= '0;
               idx_ff <= '0;
            end else begin
               row_ff <= row_next[ROW_BITS-1:0];
               idx_ff <= idx_ff + idx_type'(1);
            end
         end else begin
            col_ff <= col_next[COL_BITS-1:0];
            idx_ff <= idx_ff + idx_type'(1);
         end
      end
   end

   // line store: read-first, the old flag of this column is the row above
   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_rd_ff       <= line_mem[col_ff];
         line_mem[col_ff] <= here_nodata;
      end
   end

   // ------------------------------------------------------------------
   // stage one
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line_rd_ff still holds the previous sample's above flag here, which
   // becomes this sample's upper-left flag
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cell_ff    <= cell_now;
         s1_frozen_ff  <= frozen_now;
         s1_idx_ff     <= idx_ff;
         s1_left_ff    <= left_ff;
         s1_up_left_ff <= line_rd_ff;
         s1_here_ff    <= here_nodata;
      end
   end

   // corner indices and keep decisions
   always_comb begin
      pair.here    = s1_idx_ff;
      pair.left    = s1_idx_ff - idx_type'(1);
      pair.up      = s1_idx_ff - idx_type'(cols_eff);
      pair.up_left = s1_idx_ff - idx_type'(cols_eff) - idx_type'(1);
      pair.frozen  = s1_frozen_ff;
      pair.keep_lo = s1_cell_ff &&
                     (!nodata_enable_ff || !(s1_left_ff || line_rd_ff || s1_up_left_ff));
      pair.keep_hi = s1_cell_ff &&
                     (!nodata_enable_ff || !(s1_left_ff || s1_here_ff || line_rd_ff));
   end

   assign pair_any = pair.keep_lo || pair.keep_hi;
   // a sample with no triangle leaves without touching the output stage
   assign s1_move  = s1_valid_ff && (!pair_any || out_ready);

   // ------------------------------------------------------------------
   // output stage
   // ------------------------------------------------------------------
   hgt_tri_out u_tri_out (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (s1_valid_ff && pair_any),
      .load_ready      (out_ready),
      .pair            (pair),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_corner_a    (rsp_corner_a),
      .rsp_corner_b    (rsp_corner_b),
      .rsp_corner_c    (rsp_corner_c),
      .rsp_frozen      (rsp_frozen),
      .rsp_second_half (rsp_second_half),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // an accepted sample always lands in stage one
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted sample missing from stage one");

   // the line store output holds while stage one waits on it
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> $stable(line_rd_ff))
      else $error("line store output changed under a stalled sample");

   // a non-final triangle is followed by the upper-right one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && rsp_second_half))
      else $error("second triangle of a cell lost");
`endif

endmodule
